/* rtl/core/wst_pkg.sv */
// ----------------------------------------------------------------------------
// wst_pkg
// Shared constants and types for the word set table: sizes, field widths,
// action codes and the layout of one stored slot.
// ----------------------------------------------------------------------------
package wst_pkg;

  localparam int SET_DEPTH   = 64;
  localparam int MAX_LETTERS = 16;

  localparam int LETTER_BITS = 6;
  localparam int LOW_LETTERS = 10;
  localparam int HIGH_LETTERS = 6;
  localparam int LOW_W       = LOW_LETTERS * LETTER_BITS;
  localparam int HIGH_W      = HIGH_LETTERS * LETTER_BITS;
  localparam int LEN_W       = 5;

  localparam int IDX_W       = $clog2(SET_DEPTH);
  localparam int CNT_W       = $clog2(SET_DEPTH + 1);
  localparam int OUT_CNT_W   = 7;
  localparam int COUNT_MAX   = 127;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_QUERY  = 2'd3
  } action_e;

  typedef struct packed {
    logic [LOW_W-1:0]  lo;
    logic [HIGH_W-1:0] hi;
    logic [LEN_W-1:0]  len;
  } entry_t;

endpackage

/* rtl/core/word_set_table.sv */
// The result strobe done_o is raised once the scan, the tail state and the commit
// are through; busy_o stays high from the start of the scan through the commit.
// A new item is taken only after the last one is done, as each scans all 64 slots
// through the single read port of the slot memory, then one compare and one commit.
// Reset clears every valid mark, the member count and the control state at once;
// the slot memory itself is not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
// word_set_table
// Set of up to SET_DEPTH words held in a single-port slot memory with one
// valid flop per slot. Each command scans every slot, then commits a clear,
// insert, delete or query and reports membership, insert, full and count.
// ----------------------------------------------------------------------------
module word_set_table
  import wst_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            action_i,
  input  logic [LOW_W-1:0]      word_letters_low_i,
  input  logic [HIGH_W-1:0]     word_letters_high_i,
  input  logic [LEN_W-1:0]      word_length_i,
  output logic                  done_o,
  output logic                  was_member_o,
  output logic                  inserted_o,
  output logic                  set_full_o,
  output logic [OUT_CNT_W-1:0]  member_count_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_COMMIT
  } state_e;

  state_e               state_q;
  action_e              act_q;
  entry_t               word_q;
  entry_t               word_d;
  logic [LEN_W-1:0]     len_sat;

  entry_t               slot_mem_q [SET_DEPTH];
  entry_t               rdata_q;
  logic [SET_DEPTH-1:0] valid_q;

  logic [IDX_W-1:0]     rd_idx_q;
  logic [IDX_W-1:0]     cmp_idx_q;
  logic                 cmp_vld_q;
  logic                 hit_q;
  logic [IDX_W-1:0]     hit_idx_q;
  logic                 free_q;
  logic [IDX_W-1:0]     free_idx_q;
  logic [CNT_W-1:0]     count_q;

  logic                 accept;
  logic                 slot_valid;
  logic                 slot_match;
  logic                 commit;
  logic                 wr_en;
  logic                 del_en;
  logic                 clr_en;
  logic                 ins_d;
  logic                 full_d;
  logic [CNT_W-1:0]     count_d;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;
  assign commit = (state_q == ST_COMMIT);

  // Saturate the length, then zero every letter at or past it
  always_comb begin
    len_sat = (word_length_i > LEN_W'(MAX_LETTERS)) ? LEN_W'(MAX_LETTERS) : word_length_i;
    word_d.len = len_sat;
    for (int i = 0; i < LOW_LETTERS; i++) begin
      word_d.lo[i*LETTER_BITS +: LETTER_BITS] = (i < int'(len_sat)) ?
          word_letters_low_i[i*LETTER_BITS +: LETTER_BITS] : '0;
    end
    for (int i = 0; i < HIGH_LETTERS; i++) begin
      word_d.hi[i*LETTER_BITS +: LETTER_BITS] = (i + LOW_LETTERS < int'(len_sat)) ?
          word_letters_high_i[i*LETTER_BITS +: LETTER_BITS] : '0;
    end
  end

  // Unwritten slots are never valid, so their contents never reach the match
  assign slot_valid = valid_q[cmp_idx_q];
  assign slot_match = slot_valid && (rdata_q == word_q);

  always_comb begin
    count_d = count_q;
    ins_d   = 1'b0;
    full_d  = 1'b0;
    wr_en   = 1'b0;
    del_en  = 1'b0;
    clr_en  = 1'b0;
    if (commit) begin
      case (act_q)
        ACT_CLEAR: begin
          clr_en  = 1'b1;
          count_d = '0;
        end
        ACT_INSERT: begin
          if (!hit_q) begin
            if (free_q) begin
              wr_en   = 1'b1;
              ins_d   = 1'b1;
              count_d = count_q + CNT_W'(1);
            end else begin
              full_d = 1'b1;
            end
          end
        end
        ACT_DELETE: begin
          if (hit_q) begin
            del_en = 1'b1;
            if (count_q != '0) begin
              count_d = count_q - CNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Slot memory: reads only while scanning, writes only at commit, so the
  // two never touch the same entry in one cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem_q[free_idx_q] <= word_q;
    end
    if (state_q == ST_SCAN) begin
      rdata_q <= slot_mem_q[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      act_q          <= ACT_QUERY;
      word_q         <= '0;
      valid_q        <= '0;
      rd_idx_q       <= '0;
      cmp_idx_q      <= '0;
      cmp_vld_q      <= 1'b0;
      hit_q          <= 1'b0;
      hit_idx_q      <= '0;
      free_q         <= 1'b0;
      free_idx_q     <= '0;
      count_q        <= '0;
      done_o         <= 1'b0;
      was_member_o   <= 1'b0;
      inserted_o     <= 1'b0;
      set_full_o     <= 1'b0;
      member_count_o <= '0;
    end else begin
      done_o    <= commit;
      cmp_vld_q <= (state_q == ST_SCAN);

      // Compare stage works on the read data in the cycle after the read
      if (cmp_vld_q) begin
        if (slot_match && !hit_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= cmp_idx_q;
        end
        if (!slot_valid && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= cmp_idx_q;
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            act_q    <= action_e'(action_i);
            word_q   <= word_d;
            rd_idx_q <= '0;
            hit_q    <= 1'b0;
            free_q   <= 1'b0;
            state_q  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cmp_idx_q <= rd_idx_q;
          rd_idx_q  <= rd_idx_q + IDX_W'(1);
          if (rd_idx_q == IDX_W'(SET_DEPTH - 1)) begin
            state_q <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          state_q <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (clr_en) begin
            valid_q <= '0;
          end else if (wr_en) begin
            valid_q[free_idx_q] <= 1'b1;
          end else if (del_en) begin
            valid_q[hit_idx_q] <= 1'b0;
          end
          count_q        <= count_d;
          was_member_o   <= hit_q;
          inserted_o     <= ins_d;
          set_full_o     <= full_d;
          member_count_o <= (int'(count_d) > COUNT_MAX) ? OUT_CNT_W'(COUNT_MAX)
                                                        : OUT_CNT_W'(count_d);
          state_q        <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/wst_checker.sv */
// ----------------------------------------------------------------------------
// wst_checker
// Port-level checks on the word set table: command timing, result strobe
// placement and consistency of the result flags.
// ----------------------------------------------------------------------------
module wst_checker
  import wst_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start_i,
  input logic                 busy_o,
  input logic                 done_o,
  input logic                 was_member_o,
  input logic                 inserted_o,
  input logic                 set_full_o,
  input logic [OUT_CNT_W-1:0] member_count_o
);

  // A taken command raises busy straight away
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after command beat");

  // Result beat follows the command once the scan, tail and commit states are through
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##67 done_o)
    else $error("result beat missing at expected cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result beat while still busy");

  a_insert_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && inserted_o |-> !was_member_o && !set_full_o && member_count_o != '0)
    else $error("insert reported with conflicting flags");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> int'(member_count_o) <= SET_DEPTH)
    else $error("member count beyond table depth");

endmodule

bind word_set_table wst_checker u_wst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .was_member_o   (was_member_o),
  .inserted_o     (inserted_o),
  .set_full_o     (set_full_o),
  .member_count_o (member_count_o)
);

/* tb/tb_word_set_table.sv */
// ----------------------------------------------------------------------------
// tb_word_set_table
// Self-checking bench for the word set table. A queue of commands, directed
// then random phases over small and large word pools, feeds a falling-edge
// driver; each accepted beat updates a shadow copy of the set, and the
// rising-edge monitor checks every result strobe against the oldest outcome.
// ----------------------------------------------------------------------------
module tb_word_set_table;
  import wst_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int DRAIN_CYCLES   = 100;

  typedef struct packed {
    action_e           act;
    logic [LOW_W-1:0]  lo;
    logic [HIGH_W-1:0] hi;
    logic [LEN_W-1:0]  len;
  } command_t;

  typedef struct packed {
    logic                 was_member;
    logic                 inserted;
    logic                 set_full;
    logic [OUT_CNT_W-1:0] count;
  } outcome_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic [1:0]           action_i = ACT_QUERY;
  logic [LOW_W-1:0]     word_letters_low_i = '0;
  logic [HIGH_W-1:0]    word_letters_high_i = '0;
  logic [LEN_W-1:0]     word_length_i = '0;
  logic                 busy_o;
  logic                 done_o;
  logic                 was_member_o;
  logic                 inserted_o;
  logic                 set_full_o;
  logic [OUT_CNT_W-1:0] member_count_o;

  word_set_table uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .action_i            (action_i),
    .word_letters_low_i  (word_letters_low_i),
    .word_letters_high_i (word_letters_high_i),
    .word_length_i       (word_length_i),
    .done_o              (done_o),
    .was_member_o        (was_member_o),
    .inserted_o          (inserted_o),
    .set_full_o          (set_full_o),
    .member_count_o      (member_count_o)
  );

  // shadow copy of the set
  logic [LOW_W-1:0]  shadow_lo [SET_DEPTH];
  logic [HIGH_W-1:0] shadow_hi [SET_DEPTH];
  int unsigned       shadow_len [SET_DEPTH];
  logic              shadow_used [SET_DEPTH];
  int unsigned       shadow_count;

  command_t   pending_cmds[$];
  outcome_t   due_outcomes[$];
  outcome_t   want;
  logic       beat_taken = 1'b0;
  int         gap_left = 0;
  int         idle_cycles = 0;
  int         errors = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Masks of the letter bits that count for a given length, and the
  // saturated length itself.
  function automatic void word_masks(input logic [LEN_W-1:0] len,
                                     output logic [LOW_W-1:0] m_lo,
                                     output logic [HIGH_W-1:0] m_hi,
                                     output int unsigned n);
    logic [63:0] wide_lo;
    logic [63:0] wide_hi;
    int unsigned n_lo;
    int unsigned n_hi;
    n       = (len > MAX_LETTERS) ? MAX_LETTERS : len;
    n_lo    = (n < LOW_LETTERS) ? n : LOW_LETTERS;
    n_hi    = (n > LOW_LETTERS) ? n - LOW_LETTERS : 0;
    wide_lo = (64'd1 << (n_lo * LETTER_BITS)) - 64'd1;
    wide_hi = (64'd1 << (n_hi * LETTER_BITS)) - 64'd1;
    m_lo    = wide_lo[LOW_W-1:0];
    m_hi    = wide_hi[HIGH_W-1:0];
  endfunction

  function automatic outcome_t apply_command(command_t c);
    logic [LOW_W-1:0]  m_lo;
    logic [HIGH_W-1:0] m_hi;
    logic [LOW_W-1:0]  lo;
    logic [HIGH_W-1:0] hi;
    int unsigned       n;
    int                hit;
    int                free_slot;
    int                i;
    outcome_t          o;
    word_masks(c.len, m_lo, m_hi, n);
    lo        = c.lo & m_lo;
    hi        = c.hi & m_hi;
    hit       = -1;
    free_slot = -1;
    for (i = 0; i < SET_DEPTH; i++) begin
      if (hit < 0 && shadow_used[i] && shadow_len[i] == n &&
          shadow_lo[i] == lo && shadow_hi[i] == hi)
        hit = i;
      if (free_slot < 0 && !shadow_used[i])
        free_slot = i;
    end
    o = '0;
    o.was_member = (hit >= 0);
    case (c.act)
      ACT_CLEAR: begin
        for (i = 0; i < SET_DEPTH; i++) shadow_used[i] = 1'b0;
        shadow_count = 0;
      end
      ACT_INSERT: begin
        if (hit < 0) begin
          if (free_slot < 0) begin
            o.set_full = 1'b1;
          end else begin
            shadow_lo[free_slot]   = lo;
            shadow_hi[free_slot]   = hi;
            shadow_len[free_slot]  = n;
            shadow_used[free_slot] = 1'b1;
            shadow_count++;
            o.inserted = 1'b1;
          end
        end
      end
      ACT_DELETE: begin
        if (hit >= 0) begin
          shadow_used[hit] = 1'b0;
          if (shadow_count > 0) shadow_count--;
        end
      end
      default: ;
    endcase
    o.count = (shadow_count > COUNT_MAX) ? OUT_CNT_W'(COUNT_MAX)
                                         : OUT_CNT_W'(shadow_count);
    return o;
  endfunction

  function automatic command_t random_word();
    command_t    w;
    logic [5:0]  code;
    int unsigned r;
    int          i;
    w.act = ACT_QUERY;
    w.lo  = '0;
    w.hi  = '0;
    for (i = 0; i < MAX_LETTERS; i++) begin
      code = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 51))
                                           : 6'($urandom_range(52, 63));
      if (i < LOW_LETTERS) w.lo[i*LETTER_BITS +: LETTER_BITS] = code;
      else w.hi[(i-LOW_LETTERS)*LETTER_BITS +: LETTER_BITS] = code;
    end
    r = $urandom_range(0, 99);
    if (r < 88) w.len = LEN_W'($urandom_range(1, 16));
    else if (r < 94) w.len = '0;
    else w.len = LEN_W'($urandom_range(17, 31));
    return w;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 8);
    if (r < 97) return $urandom_range(9, 80);
    return $urandom_range(81, 200);
  endfunction

  task automatic push_cmd(action_e act, logic [LOW_W-1:0] lo,
                          logic [HIGH_W-1:0] hi, logic [LEN_W-1:0] len);
    command_t c;
    c.act = act;
    c.lo  = lo;
    c.hi  = hi;
    c.len = len;
    pending_cmds.push_back(c);
  endtask

  // driver: fields move on the falling edge only
  always @(negedge clk_i) begin
    command_t c;
    if (rst_ni) begin
      if (start_i && !beat_taken) begin
        // beat still waiting for busy to drop
      end else if (gap_left > 0) begin
        gap_left            <= gap_left - 1;
        start_i             <= 1'b0;
        action_i            <= 2'($urandom_range(0, 3));
        word_letters_low_i  <= LOW_W'({$urandom, $urandom});
        word_letters_high_i <= HIGH_W'({$urandom, $urandom});
        word_length_i       <= LEN_W'($urandom_range(0, 31));
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        start_i             <= 1'b1;
        action_i            <= c.act;
        word_letters_low_i  <= c.lo;
        word_letters_high_i <= c.hi;
        word_length_i       <= c.len;
        gap_left            <= pick_gap();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor and shadow update on the rising edge
  always @(posedge clk_i) begin
    command_t c;
    if (rst_ni) begin
      if (done_o) begin
        if (due_outcomes.size() == 0) begin
          $error("result strobe with no outcome pending");
          errors++;
        end else begin
          want = due_outcomes.pop_front();
          if (was_member_o !== want.was_member) begin
            $error("was_member: expected %0d, got %0d", want.was_member, was_member_o);
            errors++;
          end
          if (inserted_o !== want.inserted) begin
            $error("inserted: expected %0d, got %0d", want.inserted, inserted_o);
            errors++;
          end
          if (set_full_o !== want.set_full) begin
            $error("set_full: expected %0d, got %0d", want.set_full, set_full_o);
            errors++;
          end
          if (member_count_o !== want.count) begin
            $error("member_count: expected %0d, got %0d", want.count, member_count_o);
            errors++;
          end
        end
      end
      beat_taken = start_i && !busy_o;
      if (beat_taken) begin
        c.act = action_e'(action_i);
        c.lo  = word_letters_low_i;
        c.hi  = word_letters_high_i;
        c.len = word_length_i;
        due_outcomes.push_back(apply_command(c));
      end
      if (beat_taken || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[word_set_table] ERROR");
        $finish;
      end
    end
  end

  initial begin
    command_t          pool[$];
    command_t          w;
    command_t          fill;
    logic [LOW_W-1:0]  m_lo;
    logic [HIGH_W-1:0] m_hi;
    int unsigned       n;
    int unsigned       r;
    int                pool_size;
    int                phase_len;
    int                ins_pct;
    int                del_pct;
    int                k;
    int                i;
    int                total;

    for (i = 0; i < SET_DEPTH; i++) begin
      shadow_used[i] = 1'b0;
      shadow_lo[i]   = '0;
      shadow_hi[i]   = '0;
      shadow_len[i]  = 0;
    end
    shadow_count = 0;

    // directed: empty set, empty word, saturated length, masking, clear
    push_cmd(ACT_QUERY,  '0, '0, 5'd1);
    push_cmd(ACT_DELETE, '0, '0, 5'd1);
    push_cmd(ACT_CLEAR,  '0, '0, 5'd1);
    push_cmd(ACT_INSERT, '1, '1, 5'd0);
    push_cmd(ACT_QUERY,  '0, '0, 5'd0);
    push_cmd(ACT_INSERT, '1, '1, 5'd16);
    push_cmd(ACT_QUERY,  '1, '1, 5'd31);
    push_cmd(ACT_INSERT, '1, '1, 5'd20);
    push_cmd(ACT_INSERT, '1, '1, 5'd10);
    push_cmd(ACT_QUERY,  '1, '0, 5'd11);
    push_cmd(ACT_QUERY,  '1, '0, 5'd10);
    push_cmd(ACT_INSERT, 60'h673, '0, 5'd2);  // "zZ"
    push_cmd(ACT_QUERY,  60'h673, '0, 5'd3);
    push_cmd(ACT_DELETE, '1, '1, 5'd16);
    push_cmd(ACT_DELETE, '1, '1, 5'd16);
    push_cmd(ACT_INSERT, 60'haaaaaaaaaaaaaaa, 36'h555555555, 5'd16);
    push_cmd(ACT_CLEAR,  '1, '1, 5'd0);
    push_cmd(ACT_QUERY,  60'h673, '0, 5'd2);
    push_cmd(ACT_INSERT, '0, '0, 5'd1);

    // random phases; large pools push the set to full
    total = pending_cmds.size() + RANDOM_ITEMS;
    while (pending_cmds.size() < total) begin
      r = $urandom_range(0, 99);
      if (r < 40) pool_size = $urandom_range(2, 12);
      else if (r < 75) pool_size = $urandom_range(13, 60);
      else pool_size = $urandom_range(70, 100);
      pool.delete();
      for (i = 0; i < pool_size; i++) begin
        if (i > 0 && $urandom_range(0, 99) < 30) begin
          // near neighbour of the previous word
          w = pool[i-1];
          word_masks(w.len, m_lo, m_hi, n);
          if (n > 0 && $urandom_range(0, 1)) begin
            k = $urandom_range(0, n * LETTER_BITS - 1);
            if (k < LOW_W) w.lo[k] = ~w.lo[k];
            else w.hi[k-LOW_W] = ~w.hi[k-LOW_W];
          end else begin
            w.len = (n < MAX_LETTERS) ? LEN_W'(n + 1) : LEN_W'(n - 1);
          end
        end else begin
          w = random_word();
        end
        pool.push_back(w);
      end
      phase_len = $urandom_range(40, 250);
      ins_pct   = $urandom_range(25, 70);
      del_pct   = $urandom_range(10, 35);
      for (i = 0; i < phase_len && pending_cmds.size() < total; i++) begin
        if ($urandom_range(0, 99) < 8) begin
          w = random_word();
        end else begin
          w = pool[$urandom_range(0, pool.size() - 1)];
          word_masks(w.len, m_lo, m_hi, n);
          fill = random_word();
          if ($urandom_range(0, 1)) begin
            w.lo = (w.lo & m_lo) | (fill.lo & ~m_lo);
            w.hi = (w.hi & m_hi) | (fill.hi & ~m_hi);
          end else begin
            w.lo = w.lo & m_lo;
            w.hi = w.hi & m_hi;
          end
          if (n == MAX_LETTERS && $urandom_range(0, 2) == 0)
            w.len = LEN_W'($urandom_range(16, 31));
        end
        r = $urandom_range(0, 99);
        if (r < 2) w.act = ACT_CLEAR;
        else if (r < 2 + ins_pct) w.act = ACT_INSERT;
        else if (r < 2 + ins_pct + del_pct) w.act = ACT_DELETE;
        else w.act = ACT_QUERY;
        pending_cmds.push_back(w);
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(posedge clk_i);
    while (pending_cmds.size() > 0 || start_i || due_outcomes.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("[word_set_table] OK");
    end else begin
      $display("[word_set_table] ERROR");
    end
    $finish;
  end

endmodule
